[src/u8u16_pkg.sv]
// Package: shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // Default number of entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  localparam int POINT_W = 21;
  localparam int UNIT_W  = 16;
  localparam int FAULT_W = 3;

  // UTF-8 byte classes
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Code point limits
  localparam logic [POINT_W-1:0] MIN_LEN2   = 21'h80;
  localparam logic [POINT_W-1:0] MIN_LEN3   = 21'h800;
  localparam logic [POINT_W-1:0] MIN_LEN4   = 21'h10000;
  localparam logic [POINT_W-1:0] MAX_POINT  = 21'h10FFFF;
  localparam logic [POINT_W-1:0] SURR_FIRST = 21'hD800;
  localparam logic [POINT_W-1:0] SURR_LAST  = 21'hDFFF;
  localparam logic [POINT_W-1:0] BMP_LAST   = 21'hFFFF;
  localparam logic [POINT_W-1:0] PLANE_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0]  HIGH_BASE  = 16'hD800;
  localparam logic [UNIT_W-1:0]  LOW_BASE   = 16'hDC00;
  localparam logic [9:0]         TEN_MASK   = 10'h3FF;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE      = 3'd0,
    FAULT_BAD_LEAD  = 3'd1,
    FAULT_TRUNCATED = 3'd2,
    FAULT_BAD_CONT  = 3'd3,
    FAULT_INVALID   = 3'd4
  } fault_t;

  // One decoded event: a unit, a surrogate pair, or an error
  typedef struct packed {
    logic [UNIT_W-1:0] unit_first;
    logic [UNIT_W-1:0] unit_second;
    logic              pair;
    fault_t            fault;
    logic              eot;
  } rec_t;

endpackage

[src/u8u16_if.sv]
// Interfaces: UTF-8 byte channel and UTF-16 unit channel.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface u8u16_unit_if;
  logic                          valid;
  logic                          ready;
  logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
  logic [u8u16_pkg::FAULT_W-1:0] fault;
  logic                          end_of_text;
  logic                          run_last;

  modport source (output valid, output code_unit, output fault, output end_of_text,
                  output run_last, input ready);
  modport sink   (input valid, input code_unit, input fault, input end_of_text,
                  input run_last, output ready);
endinterface

[src/utf8_to_utf16_transcoder_unit.sv]
// Top level: UTF-8 to UTF-16 transcoder, front decoder, event queue, back emitter.
//
//  channel   modport  fields                                             role
//  byte_in   sink     text_byte[8], text_end                             UTF-8 bytes in
//  unit_out  source   code_unit[16], fault[3], end_of_text, run_last     UTF-16 units out
//
// One byte is taken per cycle while the queue has a free entry; an event that a byte
// completes is written at that same edge, so its first unit can leave in the next cycle.
// A surrogate pair leaves as two transactions, high unit first, from one entry.
// rst (synchronous) clears decoder state, queue pointers and the pair phase.
// A stalled output holds its transaction; input stalls only when the queue is full.
module utf8_to_utf16_transcoder_unit #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  u8u16_byte_if.sink    byte_in,
  u8u16_unit_if.source  unit_out
);

  logic            push;
  u8u16_pkg::rec_t push_rec;
  logic            full;
  logic            pop;
  u8u16_pkg::rec_t head_rec;
  logic            empty;

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .full     (full),
    .push     (push),
    .push_rec (push_rec)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (empty)
  );

  u8u16_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_rec (head_rec),
    .empty    (empty),
    .pop      (pop),
    .unit_out (unit_out)
  );

endmodule

[src/u8u16_front.sv]
// Front end: takes UTF-8 bytes, tracks sequences, checks them and pushes events.
module u8u16_front (
  input  logic                 clk,
  input  logic                 rst,
  u8u16_byte_if.sink           byte_in,
  input  logic                 full,
  output logic                 push,
  output u8u16_pkg::rec_t      push_rec
);

  logic [u8u16_pkg::POINT_W-1:0] partial_point, partial_point_next;
  logic [1:0]                    bytes_remaining, bytes_remaining_next;
  logic [2:0]                    sequence_length, sequence_length_next;
  logic                          error_latched, error_latched_next;

  logic                          accept;
  logic [7:0]                    b;
  logic                          end_flag;
  logic [u8u16_pkg::POINT_W-1:0] cp_shift;
  logic [1:0]                    rem_dec;
  logic [u8u16_pkg::POINT_W-1:0] min_val;
  logic [u8u16_pkg::POINT_W-1:0] cp_off;
  logic                          cp_bad;

  assign byte_in.ready = !full;
  assign accept        = byte_in.valid && !full;
  assign b             = byte_in.text_byte;
  assign end_flag      = byte_in.text_end;

  // Datapath for a continuation byte
  assign cp_shift = {partial_point[u8u16_pkg::POINT_W-7:0], b[5:0]};
  assign rem_dec  = bytes_remaining - 2'd1;
  assign cp_off   = cp_shift - u8u16_pkg::PLANE_BASE;

  always_comb begin
    unique case (sequence_length)
      3'd2:    min_val = u8u16_pkg::MIN_LEN2;
      3'd3:    min_val = u8u16_pkg::MIN_LEN3;
      default: min_val = u8u16_pkg::MIN_LEN4;
    endcase
  end

  assign cp_bad = (cp_shift < min_val) || (cp_shift > u8u16_pkg::MAX_POINT) ||
                  ((cp_shift >= u8u16_pkg::SURR_FIRST) && (cp_shift <= u8u16_pkg::SURR_LAST));

  // Sequence tracking and event build
  always_comb begin
    partial_point_next   = partial_point;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    error_latched_next   = error_latched;
    push                 = 1'b0;
    push_rec.unit_first  = '0;
    push_rec.unit_second = '0;
    push_rec.pair        = 1'b0;
    push_rec.fault       = u8u16_pkg::FAULT_NONE;
    push_rec.eot         = end_flag;

    if (accept) begin
      if (error_latched) begin
        // drop bytes until end of text
        if (end_flag) begin
          partial_point_next   = '0;
          bytes_remaining_next = '0;
          sequence_length_next = '0;
          error_latched_next   = 1'b0;
        end
      end else if (bytes_remaining == 2'd0) begin
        partial_point_next   = '0;
        bytes_remaining_next = '0;
        sequence_length_next = '0;
        if (b[7] == 1'b0) begin
          push                = 1'b1;
          push_rec.unit_first = {8'h00, b};
        end else if (((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) ||
                     ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) ||
                     ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG)) begin
          if (end_flag) begin
            push           = 1'b1;
            push_rec.fault = u8u16_pkg::FAULT_TRUNCATED;
            push_rec.eot   = 1'b1;
          end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
            sequence_length_next = 3'd2;
            bytes_remaining_next = 2'd1;
            partial_point_next   = {16'h0000, b[4:0]};
          end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
            sequence_length_next = 3'd3;
            bytes_remaining_next = 2'd2;
            partial_point_next   = {17'h00000, b[3:0]};
          end else begin
            sequence_length_next = 3'd4;
            bytes_remaining_next = 2'd3;
            partial_point_next   = {18'h00000, b[2:0]};
          end
        end else begin
          push               = 1'b1;
          push_rec.fault     = u8u16_pkg::FAULT_BAD_LEAD;
          push_rec.eot       = 1'b1;
          error_latched_next = !end_flag;
        end
      end else if ((b & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG) begin
        // broken sequence
        partial_point_next   = '0;
        bytes_remaining_next = '0;
        sequence_length_next = '0;
        push                 = 1'b1;
        push_rec.fault       = u8u16_pkg::FAULT_BAD_CONT;
        push_rec.eot         = 1'b1;
        error_latched_next   = !end_flag;
      end else if (rem_dec != 2'd0) begin
        partial_point_next   = cp_shift;
        bytes_remaining_next = rem_dec;
        if (end_flag) begin
          partial_point_next   = '0;
          bytes_remaining_next = '0;
          sequence_length_next = '0;
          push                 = 1'b1;
          push_rec.fault       = u8u16_pkg::FAULT_TRUNCATED;
          push_rec.eot         = 1'b1;
        end
      end else begin
        // sequence complete
        partial_point_next   = '0;
        bytes_remaining_next = '0;
        sequence_length_next = '0;
        push                 = 1'b1;
        if (cp_bad) begin
          push_rec.fault     = u8u16_pkg::FAULT_INVALID;
          push_rec.eot       = 1'b1;
          error_latched_next = !end_flag;
        end else if (cp_shift <= u8u16_pkg::BMP_LAST) begin
          push_rec.unit_first = cp_shift[u8u16_pkg::UNIT_W-1:0];
        end else begin
          push_rec.pair        = 1'b1;
          push_rec.unit_first  = u8u16_pkg::HIGH_BASE +
                                 {6'd0, cp_off[19:10] & u8u16_pkg::TEN_MASK};
          push_rec.unit_second = u8u16_pkg::LOW_BASE +
                                 {6'd0, cp_off[9:0] & u8u16_pkg::TEN_MASK};
        end
      end
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point   <= '0;
      bytes_remaining <= '0;
      sequence_length <= '0;
      error_latched   <= 1'b0;
    end else begin
      partial_point   <= partial_point_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      error_latched   <= error_latched_next;
    end
  end

endmodule

[src/u8u16_queue.sv]
// Event queue: small register FIFO between front and back end.
module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::rec_t push_rec,
  output logic            full,
  input  logic            pop,
  output u8u16_pkg::rec_t head_rec,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8u16_pkg::rec_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_rec = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/u8u16_back.sv]
// Back end: expands queued events into UTF-16 unit transactions.
module u8u16_back (
  input  logic            clk,
  input  logic            rst,
  input  u8u16_pkg::rec_t head_rec,
  input  logic            empty,
  output logic            pop,
  u8u16_unit_if.source    unit_out
);

  // second half of a surrogate pair is pending
  logic phase;
  logic out_take;

  assign unit_out.valid       = !empty;
  assign out_take             = !empty && unit_out.ready;
  assign pop                  = out_take && (!head_rec.pair || phase);

  assign unit_out.code_unit   = phase ? head_rec.unit_second : head_rec.unit_first;
  assign unit_out.fault       = head_rec.fault;
  assign unit_out.end_of_text = head_rec.eot && (!head_rec.pair || phase);
  assign unit_out.run_last    = !head_rec.pair || phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (out_take) begin
      phase <= head_rec.pair && !phase;
    end
  end

endmodule

[verif/testbench.sv]
// Testbench for the UTF-8 to UTF-16 transcoder: byte stimulus, decode prediction, unit checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       fin;
  } text_item_t;

  typedef struct {
    logic [UNIT_W-1:0] unit;
    fault_t            fault;
    logic              eot;
    logic              last;
  } unit_rec_t;

  logic clk;
  logic rst;

  u8u16_byte_if byte_if ();
  u8u16_unit_if unit_if ();

  utf8_to_utf16_transcoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .unit_out (unit_if)
  );

  text_item_t  byte_backlog[$];
  unit_rec_t   pending_units[$];
  logic [7:0]  text_bytes[$];
  int          mismatch_count = 0;
  int          accepted_count = 0;
  int          total_items = 1;
  int          idle_pct;
  int          stall_pct;

  // Decoder state mirrored by the predictor
  logic [POINT_W-1:0] seq_bits;
  logic [1:0]         conts_left;
  logic [2:0]         seq_len;
  logic               in_error;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function void expect_result(input logic [UNIT_W-1:0] unit, input fault_t f,
                              input logic eot, input logic last);
    unit_rec_t r;
    r.unit  = unit;
    r.fault = f;
    r.eot   = eot;
    r.last  = last;
    pending_units.insert(pending_units.size(), r);
  endfunction

  function void flag_error(input fault_t f, input logic fin);
    seq_bits   = '0;
    conts_left = '0;
    seq_len    = '0;
    in_error   = !fin;
    expect_result('0, f, 1'b1, 1'b1);
  endfunction

  // One unit in the basic plane, otherwise a high/low surrogate pair
  function void emit_point(input logic [POINT_W-1:0] cp, input logic fin);
    logic [POINT_W-1:0] v;
    if (cp <= BMP_LAST) begin
      expect_result(cp[UNIT_W-1:0], FAULT_NONE, fin, 1'b1);
    end else begin
      v = cp - PLANE_BASE;
      expect_result(HIGH_BASE + UNIT_W'(v[19:10]), FAULT_NONE, 1'b0, 1'b0);
      expect_result(LOW_BASE + UNIT_W'(v[9:0] & TEN_MASK), FAULT_NONE, fin, 1'b1);
    end
  endfunction

  function void decode_byte(input logic [7:0] b, input logic fin);
    logic [POINT_W-1:0] cp;
    logic [POINT_W-1:0] floor_v;
    // after an error, swallow bytes until the end of the text
    if (in_error) begin
      if (fin) begin
        seq_bits   = '0;
        conts_left = '0;
        seq_len    = '0;
        in_error   = 1'b0;
      end
      return;
    end
    // lead byte
    if (conts_left == 0) begin
      if (b < 8'h80) begin
        emit_point(POINT_W'(b), fin);
        return;
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        seq_len = 3'd2; conts_left = 2'd1; seq_bits = POINT_W'(b[4:0]);
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        seq_len = 3'd3; conts_left = 2'd2; seq_bits = POINT_W'(b[3:0]);
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
        seq_len = 3'd4; conts_left = 2'd3; seq_bits = POINT_W'(b[2:0]);
      end else begin
        flag_error(FAULT_BAD_LEAD, fin);
        return;
      end
      if (fin) flag_error(FAULT_TRUNCATED, fin);
      return;
    end
    // continuation byte, checked as it arrives
    if ((b & CONT_MASK) != CONT_TAG) begin
      flag_error(FAULT_BAD_CONT, fin);
      return;
    end
    seq_bits   = {seq_bits[POINT_W-7:0], b[5:0]};
    conts_left = conts_left - 2'd1;
    if (conts_left != 0) begin
      if (fin) flag_error(FAULT_TRUNCATED, fin);
      return;
    end
    // sequence complete: overlong, range and surrogate checks
    cp      = seq_bits;
    floor_v = (seq_len == 3'd2) ? MIN_LEN2 : (seq_len == 3'd3) ? MIN_LEN3 : MIN_LEN4;
    seq_bits = '0;
    seq_len  = '0;
    if (cp < floor_v || cp > MAX_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST))
      flag_error(FAULT_INVALID, fin);
    else
      emit_point(cp, fin);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  // Move the text under construction to the backlog, marking its last byte
  task flush_text();
    text_item_t it;
    for (int i = 0; i < text_bytes.size(); i++) begin
      it.b   = text_bytes[i];
      it.fin = (i == text_bytes.size() - 1);
      byte_backlog.insert(byte_backlog.size(), it);
    end
    text_bytes.delete();
  endtask

  // Append one byte to the text under construction
  function void add_byte(input logic [7:0] v);
    text_bytes.insert(text_bytes.size(), v);
  endfunction

  // Encode cp in n bytes; n larger than needed gives an overlong form
  task add_point(input logic [POINT_W-1:0] cp, input int n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Legal code point for an n-byte form, often at the edges of the range
  function logic [POINT_W-1:0] pick_point(input int n);
    logic [POINT_W-1:0] lo;
    logic [POINT_W-1:0] hi;
    logic [POINT_W-1:0] cp;
    int sel;
    case (n)
      1:       begin lo = 21'h0;     hi = 21'h7F;   end
      2:       begin lo = MIN_LEN2;  hi = 21'h7FF;  end
      3:       begin lo = MIN_LEN3;  hi = BMP_LAST; end
      default: begin lo = MIN_LEN4;  hi = MAX_POINT; end
    endcase
    sel = $urandom_range(7);
    if (sel == 0)      cp = lo;
    else if (sel == 1) cp = hi;
    else               cp = POINT_W'($urandom_range(hi, lo));
    // push surrogates up into 0xF800..0xFFFF
    if (cp >= SURR_FIRST && cp <= SURR_LAST) cp = cp ^ 21'h2000;
    return cp;
  endfunction

  // One random text: mostly legal points, some broken sequences and noise
  task add_text();
    int points, kind, n, idx;
    logic [1:0] top;
    logic stop;
    points = $urandom_range(6, 1);
    stop   = 1'b0;
    for (int k = 0; k < points && !stop; k++) begin
      kind = $urandom_range(99);
      n    = $urandom_range(4, 1);
      if (kind < 75) begin
        add_point(pick_point(n), n);
      end else if (kind < 79) begin
        // bad lead: stray continuation or 0xF8..0xFF
        if ($urandom_range(1)) add_byte(8'($urandom_range(8'hBF, 8'h80)));
        else                   add_byte(8'($urandom_range(8'hFF, 8'hF8)));
      end else if (kind < 83) begin
        // overlong
        n = $urandom_range(4, 2);
        add_point(POINT_W'($urandom_range((n == 2) ? 32'h7F : (n == 3) ? 32'h7FF : 32'hFFFF)),
                  n);
      end else if (kind < 86) begin
        add_point(POINT_W'($urandom_range(SURR_LAST, SURR_FIRST)), 3);
      end else if (kind < 89) begin
        add_point(POINT_W'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
      end else if (kind < 93) begin
        // truncated: cut the sequence and end the text there
        n = $urandom_range(4, 2);
        add_point(pick_point(n), n);
        repeat ($urandom_range(n - 1, 1)) void'(text_bytes.pop_back());
        stop = 1'b1;
      end else if (kind < 97) begin
        // bad continuation somewhere in the sequence
        n = $urandom_range(4, 2);
        add_point(pick_point(n), n);
        idx = text_bytes.size() - $urandom_range(n - 1, 1);
        case ($urandom_range(2))
          0:       top = 2'b00;
          1:       top = 2'b01;
          default: top = 2'b11;
        endcase
        text_bytes[idx] = {top, 6'($urandom)};
      end else begin
        add_byte(8'($urandom));
      end
    end
    flush_text();
  endtask

  // ---------------------------------------------------------------------------
  // Idle/stall phases, by progress through the input
  // ---------------------------------------------------------------------------
  always_comb begin
    case ((accepted_count * 4) / total_items)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 67; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 67; end
      default: begin idle_pct = 35; stall_pct = 35; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Driver: byte channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    text_item_t nxt;
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        decode_byte(byte_if.text_byte, byte_if.text_end);
        accepted_count <= accepted_count + 1;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (byte_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = byte_backlog.pop_front();
          byte_if.valid     <= 1'b1;
          byte_if.text_byte <= nxt.b;
          byte_if.text_end  <= nxt.fin;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: unit channel, compared with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    unit_rec_t want;
    if (rst) begin
      unit_if.ready <= 1'b0;
    end else begin
      unit_if.ready <= ($urandom_range(99) >= stall_pct);
      if (unit_if.valid && unit_if.ready) begin
        if (pending_units.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h fault %0d eot %b last %b",
                                    unit_if.code_unit, unit_if.fault,
                                    unit_if.end_of_text, unit_if.run_last));
        end else begin
          want = pending_units.pop_front();
          if (unit_if.code_unit !== want.unit || unit_if.fault !== want.fault ||
              unit_if.end_of_text !== want.eot || unit_if.run_last !== want.last)
            report_mismatch($sformatf(
              "got unit %h fault %0d eot %b last %b, want unit %h fault %0d eot %b last %b",
              unit_if.code_unit, unit_if.fault, unit_if.end_of_text, unit_if.run_last,
              want.unit, want.fault, want.eot, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, load stimulus, drain, finish
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst               = 1'b1;
    byte_if.valid     = 1'b0;
    byte_if.text_byte = 8'h00;
    byte_if.text_end  = 1'b0;
    unit_if.ready     = 1'b0;
    seq_bits          = '0;
    conts_left        = '0;
    seq_len           = '0;
    in_error          = 1'b0;

    // legal points at the edges 0x00, 0x7F, 0x80 and 0xFFFF, then a surrogate pair at both ends
    text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    flush_text();
    text_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    flush_text();
    // overlong, then a byte swallowed that clears the state at the end
    text_bytes = '{8'hC0, 8'h80, 8'hFF};
    flush_text();
    // bad lead on the final byte
    text_bytes = '{8'hFF};
    flush_text();
    // truncated after a good continuation
    text_bytes = '{8'hE2, 8'h82};
    flush_text();
    // bad continuation on the final byte wins over truncation
    text_bytes = '{8'hE2, 8'h41};
    flush_text();
    // encoded surrogate
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    flush_text();
    // above the last code point
    text_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
    flush_text();

    while (byte_backlog.size() < 730) add_text();
    total_items = byte_backlog.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_backlog.size() != 0 || byte_if.valid || pending_units.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
